// ----- sv/sra_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sra_pkg: shared constants for the status report battery average block
// field widths of the stream words and the bit positions of the flag byte
// ----------------------------------------------------------------------------
package sra_pkg;

    // field widths
    localparam int FLAGS_W     = 8;
    localparam int READ_W      = 16;
    localparam int MEAN_W      = 20;
    localparam int FRAC_W      = 4;
    localparam int OUT_FIELD_W = 1 + 3 * READ_W + MEAN_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // flag byte bit positions
    localparam int FLAG_PLUGGED_BIT   = 0;
    localparam int FLAG_FAN_BIT       = 1;
    localparam int FLAG_BACKLIGHT_BIT = 2;

endpackage
`default_nettype wire

// ----- sv/sra_window.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sra_window: boxcar window of battery samples
// ring memory, running sum and saturating fill count; a push runs its
// steps in order (read old entry and write new, subtract, add)
// ----------------------------------------------------------------------------
module sra_window #(
    parameter int WINDOW_LENGTH = 16,
    parameter int SUM_W         = 16 + $clog2(WINDOW_LENGTH),
    parameter int CNT_W         = $clog2(WINDOW_LENGTH + 1)
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_push,
    input  wire logic signed [sra_pkg::READ_W-1:0] i_sample,
    output logic                                 o_done,
    output logic signed [SUM_W-1:0]              o_sum,
    output logic        [CNT_W-1:0]              o_count
);

    localparam int SLOT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

    typedef enum logic [1:0] {
        W_IDLE,
        W_SUB,
        W_ADD
    } t_win_state;

    t_win_state                        r_state;
    logic signed [sra_pkg::READ_W-1:0] r_ring [WINDOW_LENGTH];
    logic signed [sra_pkg::READ_W-1:0] r_old;
    logic signed [sra_pkg::READ_W-1:0] r_new;
    logic                              r_full;
    logic        [SLOT_W-1:0]          r_slot;
    logic        [SLOT_W-1:0]          n_slot;
    logic        [CNT_W-1:0]           r_count;
    logic signed [SUM_W-1:0]           r_sum;
    logic                              r_done;
    logic                              w_full;

    // slot wraps at the window length
    assign n_slot = (r_slot == SLOT_W'(WINDOW_LENGTH - 1)) ? '0 : r_slot + 1'b1;
    assign w_full = (r_count == CNT_W'(WINDOW_LENGTH));

    // ring memory: old entry read while the new one is written
    always_ff @(posedge i_clk) begin
        if (r_state == W_IDLE && i_push) begin
            r_old          <= r_ring[r_slot];
            r_ring[r_slot] <= i_sample;
            r_new          <= i_sample;
            r_full         <= w_full;
        end
    end

    // sum, slot and count sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
            r_slot  <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == W_ADD);
            unique case (r_state)
                W_IDLE: begin
                    if (i_push) begin
                        r_slot  <= n_slot;
                        if (!w_full) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= W_SUB;
                    end
                end
                W_SUB: begin
                    // entries not yet written count as zero
                    if (r_full) begin
                        r_sum <= r_sum - SUM_W'(r_old);
                    end
                    r_state <= W_ADD;
                end
                W_ADD: begin
                    r_sum   <= r_sum + SUM_W'(r_new);
                    r_state <= W_IDLE;
                end
                default: r_state <= W_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_sum   = r_sum;
    assign o_count = r_count;

endmodule
`default_nettype wire

// ----- sv/sra_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sra_divider: bit-serial restoring divider for the window mean
// divides |sum| * 16 by the fill count one quotient bit per cycle,
// then restores the sign, so the result truncates toward zero
// ----------------------------------------------------------------------------
module sra_divider #(
    parameter int SUM_W = 20,
    parameter int CNT_W = 5
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_start,
    input  wire logic signed [SUM_W-1:0]           i_sum,
    input  wire logic        [CNT_W-1:0]           i_count,
    output logic                                   o_done,
    output logic signed [sra_pkg::MEAN_W-1:0]      o_mean
);

    localparam int MAG_W = SUM_W + sra_pkg::FRAC_W;
    localparam int REM_W = CNT_W + 1;
    localparam int IT_W  = $clog2(MAG_W + 1);

    logic [MAG_W-1:0] r_acc;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_div;
    logic             r_neg;
    logic [IT_W-1:0]  r_it;
    logic             r_busy;
    logic             r_fin;
    logic             r_done;
    logic signed [sra_pkg::MEAN_W-1:0] r_mean;

    logic [SUM_W-1:0] w_mag;
    logic [REM_W-1:0] w_rem_sh;
    logic [REM_W:0]   w_diff;
    logic [MAG_W-1:0] w_quot;

    // magnitude of the sum, read as unsigned
    assign w_mag    = i_sum[SUM_W-1] ? (~i_sum + 1'b1) : i_sum;
    // shift next dividend bit into the partial remainder
    assign w_rem_sh = {r_rem, r_acc[MAG_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_div};
    assign w_quot   = r_neg ? (~r_acc + 1'b1) : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_it   <= '0;
        end else begin
            r_fin  <= !i_start && r_busy && (r_it == IT_W'(1));
            r_done <= !i_start && !r_busy && r_fin;
            if (i_start) begin
                r_acc  <= {w_mag, {sra_pkg::FRAC_W{1'b0}}};
                r_rem  <= '0;
                r_div  <= i_count;
                r_neg  <= i_sum[SUM_W-1];
                r_it   <= IT_W'(MAG_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // one quotient bit per cycle
                if (!w_diff[REM_W]) begin
                    r_rem <= w_diff[CNT_W-1:0];
                    r_acc <= {r_acc[MAG_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh[CNT_W-1:0];
                    r_acc <= {r_acc[MAG_W-2:0], 1'b0};
                end
                r_it <= r_it - 1'b1;
                if (r_it == IT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else if (r_fin) begin
                r_mean <= w_quot[sra_pkg::MEAN_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_mean = r_mean;

endmodule
`default_nettype wire

// ----- sv/status_report_battery_average.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// status_report_battery_average: status report decoder with battery average
// routes each report to its held value and keeps a boxcar mean of samples
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one status report per word: tuser is the flag byte,
//   tdata the signed reading. m_axis returns one word per report with
//   every held value and the battery mean in Q4.
//   A fan or backlight report moves the core to its put state, which loads
//   the output register once it is free; the core then returns to idle
//   and takes the next report. A battery sample is pushed into the window
//   (read old entry and write new, subtract, add), whose done strobe starts
//   the bit-serial divider (sum bits plus four fraction bits, one quotient
//   bit a cycle); the registered mean then goes to the put state and loads
//   the output register in the same way. One report is in work at a time;
//   for battery samples the divider loop sets the rate.
//   s_axis_tready is high whenever the core is idle, also while a result
//   waits in the output register; if the receiver stalls, the next result
//   waits in the core and no further report is taken.
//   Reset clears every held value, the sum, slot, fill count and mean; the
//   ring needs no clearing since an old entry is subtracted only once full.
// ----------------------------------------------------------------------------
module status_report_battery_average #(
    parameter int WINDOW_LENGTH = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // reading[15:0]
    input  wire  [sra_pkg::READ_W-1:0]           s_axis_tdata,
    // flags[7:0]
    input  wire  [sra_pkg::FLAGS_W-1:0]          s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // plugged_in[0], fan_level[16:1], backlight_level[32:17],
    // battery_level[48:33], battery_mean_q4[68:49], zero fill above
    output logic [sra_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int SUM_W = sra_pkg::READ_W + $clog2(WINDOW_LENGTH);
    localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WIN,
        S_DIV,
        S_PUT
    } t_core_state;

    t_core_state                        r_state;
    logic                               r_plugged;
    logic signed [sra_pkg::READ_W-1:0]  r_fan;
    logic signed [sra_pkg::READ_W-1:0]  r_backlight;
    logic signed [sra_pkg::READ_W-1:0]  r_battery;
    logic signed [sra_pkg::MEAN_W-1:0]  r_mean;
    logic                               r_m_valid;
    logic [sra_pkg::OUT_TDATA_W-1:0]    r_m_data;
    logic                               r_push;

    logic                               w_accept;
    logic                               w_load;
    logic                               w_win_done;
    logic signed [SUM_W-1:0]            w_sum;
    logic        [CNT_W-1:0]            w_count;
    logic                               w_div_done;
    logic signed [sra_pkg::MEAN_W-1:0]  w_div_mean;
    logic [sra_pkg::OUT_FIELD_W-1:0]    w_word;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    // output register free or emptied this cycle
    assign w_load        = (r_state == S_PUT) && (!r_m_valid || m_axis_tready);

    // result word, zero filled to whole bytes
    assign w_word = {r_mean, r_battery, r_backlight, r_fan, r_plugged};

    // report decode, hold registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_plugged   <= 1'b0;
            r_fan       <= '0;
            r_backlight <= '0;
            r_battery   <= '0;
            r_mean      <= '0;
            r_m_valid   <= 1'b0;
            r_push      <= 1'b0;
        end else begin
            r_push    <= w_accept && !s_axis_tuser[sra_pkg::FLAG_FAN_BIT]
                         && !s_axis_tuser[sra_pkg::FLAG_BACKLIGHT_BIT];
            r_m_valid <= w_load || (r_m_valid && !m_axis_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_plugged <= s_axis_tuser[sra_pkg::FLAG_PLUGGED_BIT];
                        // fan wins over backlight, the rest are battery samples
                        priority if (s_axis_tuser[sra_pkg::FLAG_FAN_BIT]) begin
                            r_fan   <= s_axis_tdata;
                            r_state <= S_PUT;
                        end else if (s_axis_tuser[sra_pkg::FLAG_BACKLIGHT_BIT]) begin
                            r_backlight <= s_axis_tdata;
                            r_state     <= S_PUT;
                        end else begin
                            r_battery <= s_axis_tdata;
                            r_state   <= S_WIN;
                        end
                    end
                end
                S_WIN: begin
                    if (w_win_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_mean  <= w_div_mean;
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (w_load) begin
                        r_m_data <= sra_pkg::OUT_TDATA_W'(w_word);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    sra_window #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SUM_W         (SUM_W),
        .CNT_W         (CNT_W)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (r_push),
        .i_sample (r_battery),
        .o_done   (w_win_done),
        .o_sum    (w_sum),
        .o_count  (w_count)
    );

    sra_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_win_done),
        .i_sum   (w_sum),
        .i_count (w_count),
        .o_done  (w_div_done),
        .o_mean  (w_div_mean)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
`default_nettype wire

// ----- sv/sra_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sra_checker: port-level checks for the status report battery average
// watches the stream ports over time; bound to the top level below
// ----------------------------------------------------------------------------
module sra_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               s_axis_tvalid,
    input wire                               s_axis_tready,
    input wire                               m_axis_tvalid,
    input wire                               m_axis_tready,
    input wire [sra_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid after reset");

    // one report in work at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("report taken while previous one in work");

    // fill bits above the result fields stay zero
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[sra_pkg::OUT_TDATA_W-1:sra_pkg::OUT_FIELD_W] == '0)
        else $error("fill bits set in result word");

endmodule

bind status_report_battery_average sra_checker u_sra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
